>>> design/assert_macros.svh
// Assertion macros shared by the RTL of the UTF-8 stream decoder.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> design/usd_pkg.sv
// Types, constants and helper functions of the UTF-8 stream decoder.
// No dependencies; used by utf8_stream_decoder.
`default_nettype none

package usd_pkg;

    localparam int CP_W  = 21;
    localparam int LEN_W = 3;
    localparam int QUEUE_DEPTH = 3;

    localparam logic [CP_W-1:0] CP_MIN_3B    = 21'h000800;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_MATCH = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'h1F;
    localparam logic [7:0] LEAD3_MASK = 8'h0F;
    localparam logic [7:0] LEAD4_MASK = 8'h07;
    localparam logic [7:0] CONT_BITS  = 8'h3F;

    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

    typedef enum logic [1:0] {
        KIND_CODE = 2'd0,
        KIND_BAD  = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind           kind;
        logic [CP_W-1:0] cp;
        logic            last;
    } t_result;

    // Sequence length from the top five bits of a lead byte, zero if invalid
    function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
        logic [LEN_W-1:0] len;
        priority if (b[7] == 1'b0)      len = LEN_1;
        else if (b[6] == 1'b0)          len = LEN_NONE;
        else if (b[5] == 1'b0)          len = LEN_2;
        else if (b[4] == 1'b0)          len = LEN_3;
        else if (b[3] == 1'b0)          len = LEN_4;
        else                            len = LEN_NONE;
        return len;
    endfunction

endpackage

`default_nettype wire

>>> design/utf8_stream_decoder.sv
// Each result is registered in the result queue before the master side shows it.
// Throughput: one byte per cycle; a byte with two results (sequence cut by a one-byte
// or invalid lead, end with a partial sequence) yields two output beats, and the
// three-entry result queue stalls the slave side only while two or more results wait.
// Reset (synchronous, active low) empties the queue and drops any pending sequence.
// Depends on usd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module utf8_stream_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // end_marker
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast    // last
);

    localparam int CW = usd_pkg::CP_W;
    localparam int LW = usd_pkg::LEN_W;

    // decoder state
    logic [LW-1:0]  r_exp, n_exp;
    logic [1:0]     r_seen, n_seen;
    logic [CW-1:0]  r_pv, n_pv;

    // result queue, head at entry 0
    usd_pkg::t_result r_q [usd_pkg::QUEUE_DEPTH];
    usd_pkg::t_result n_q [usd_pkg::QUEUE_DEPTH];
    logic [1:0]       r_cnt, n_cnt;

    logic s_beat, m_beat;

    // results produced by this beat, in order
    usd_pkg::t_result res0, res1, first_r, second_r;
    logic             first_v, second_v;
    logic [1:0]       n_res;

    logic [7:0]     b;
    logic [LW-1:0]  lead_len;
    logic [LW-1:0]  seen_inc;
    logic [CW-1:0]  pv_shift;
    logic           is_cont;
    logic           bad_fin;
    logic [CW-1:0]  lead_bits;

    // terms for the checks at the end
    logic [CW-1:0]  out_cp;
    logic           chk_end, chk_code, chk_nocode, chk_cp_ok, chk_zero;
    logic           chk_end_in, chk_idle;

    assign s_axis_tready = (r_cnt <= 2'd1);
    assign s_beat        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_beat        = m_axis_tvalid && m_axis_tready;

    assign m_axis_tdata = {3'b000, r_q[0].cp};
    assign m_axis_tuser = r_q[0].kind;
    assign m_axis_tlast = r_q[0].last;

    assign b        = s_axis_tdata;
    assign lead_len = usd_pkg::lead_length(b);
    assign is_cont  = ((b & usd_pkg::CONT_MASK) == usd_pkg::CONT_MATCH);
    assign seen_inc = {1'b0, r_seen} + 3'd1;
    assign pv_shift = {r_pv[CW-7:0], b[5:0]};

    always_comb begin
        unique case (lead_len)
            usd_pkg::LEN_2: lead_bits = {13'd0, b & usd_pkg::LEAD2_MASK};
            usd_pkg::LEN_3: lead_bits = {13'd0, b & usd_pkg::LEAD3_MASK};
            default:        lead_bits = {13'd0, b & usd_pkg::LEAD4_MASK};
        endcase
    end

    always_comb begin
        bad_fin = 1'b0;
        if (r_exp == usd_pkg::LEN_3) begin
            bad_fin = (pv_shift < usd_pkg::CP_MIN_3B) ||
                      ((pv_shift >= usd_pkg::CP_SURR_LO) && (pv_shift <= usd_pkg::CP_SURR_HI));
        end else if (r_exp == usd_pkg::LEN_4) begin
            bad_fin = (pv_shift > usd_pkg::CP_MAX);
        end
    end

    // decode one beat against the pending sequence
    always_comb begin
        logic take_lead;
        take_lead = 1'b0;
        n_exp     = r_exp;
        n_seen    = r_seen;
        n_pv      = r_pv;
        first_v   = 1'b0;
        first_r   = '{kind: usd_pkg::KIND_BAD, cp: '0, last: 1'b0};
        second_v  = 1'b0;
        second_r  = '{kind: usd_pkg::KIND_BAD, cp: '0, last: 1'b0};

        if (s_axis_tlast) begin
            first_v  = (r_exp != usd_pkg::LEN_NONE);
            second_v = 1'b1;
            second_r.kind = usd_pkg::KIND_END;
            n_exp  = usd_pkg::LEN_NONE;
            n_seen = 2'd0;
            n_pv   = '0;
        end else if (r_exp != usd_pkg::LEN_NONE) begin
            if (is_cont) begin
                if (seen_inc >= r_exp) begin
                    second_v = 1'b1;
                    if (!bad_fin) begin
                        second_r.kind = usd_pkg::KIND_CODE;
                        second_r.cp   = pv_shift;
                    end
                    n_exp  = usd_pkg::LEN_NONE;
                    n_seen = 2'd0;
                    n_pv   = '0;
                end else begin
                    n_seen = seen_inc[1:0];
                    n_pv   = pv_shift;
                end
            end else begin
                // drop the pending sequence and treat the byte as a fresh lead
                first_v   = 1'b1;
                take_lead = 1'b1;
                n_exp     = usd_pkg::LEN_NONE;
                n_seen    = 2'd0;
                n_pv      = '0;
            end
        end else begin
            take_lead = 1'b1;
        end

        if (take_lead) begin
            if (lead_len == usd_pkg::LEN_1) begin
                second_v      = 1'b1;
                second_r.kind = usd_pkg::KIND_CODE;
                second_r.cp   = {13'd0, b};
            end else if (lead_len == usd_pkg::LEN_NONE) begin
                second_v = 1'b1;
            end else begin
                n_exp  = lead_len;
                n_seen = 2'd1;
                n_pv   = lead_bits;
            end
        end
    end

    // compact the results and mark the final one
    always_comb begin
        res1 = second_r;
        if (first_v) begin
            res0 = first_r;
            res1.last = 1'b1;
            res0.last = !second_v;
        end else begin
            res0 = second_r;
            res0.last = 1'b1;
        end
        n_res = {1'b0, first_v} + {1'b0, second_v};
    end

    // queue update: pop the head, then append this beat's results
    always_comb begin
        logic [1:0] cnt_pop;
        logic [1:0] idx;
        cnt_pop = r_cnt - {1'b0, m_beat};
        idx     = cnt_pop;
        n_q[0]  = m_beat ? r_q[1] : r_q[0];
        n_q[1]  = m_beat ? r_q[2] : r_q[1];
        n_q[2]  = r_q[2];
        n_cnt   = cnt_pop;
        if (s_beat) begin
            n_cnt = cnt_pop + n_res;
            if (n_res != 2'd0) begin
                idx = cnt_pop;
                unique case (idx)
                    2'd0:    n_q[0] = res0;
                    2'd1:    n_q[1] = res0;
                    default: n_q[2] = res0;
                endcase
            end
            if (n_res == 2'd2) begin
                idx = cnt_pop + 2'd1;
                unique case (idx)
                    2'd0:    n_q[0] = res1;
                    2'd1:    n_q[1] = res1;
                    default: n_q[2] = res1;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp  <= usd_pkg::LEN_NONE;
            r_seen <= 2'd0;
            r_pv   <= '0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (s_beat) begin
                r_exp  <= n_exp;
                r_seen <= n_seen;
                r_pv   <= n_pv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign out_cp     = m_axis_tdata[CW-1:0];
    assign chk_end    = m_axis_tvalid && (m_axis_tuser == usd_pkg::KIND_END);
    assign chk_code   = m_axis_tvalid && (m_axis_tuser == usd_pkg::KIND_CODE);
    assign chk_nocode = m_axis_tvalid && (m_axis_tuser != usd_pkg::KIND_CODE);
    assign chk_cp_ok  = (out_cp <= usd_pkg::CP_MAX) &&
                        ((out_cp < usd_pkg::CP_SURR_LO) || (out_cp > usd_pkg::CP_SURR_HI));
    assign chk_zero   = (m_axis_tdata == 24'd0);
    assign chk_end_in = s_beat && s_axis_tlast;
    assign chk_idle   = (r_exp == usd_pkg::LEN_NONE);

    `ASSERT_IMPLIES(a_end_is_last, i_clk, i_rst_n, chk_end, m_axis_tlast, "end not last")
    `ASSERT_IMPLIES(a_code_valid, i_clk, i_rst_n, chk_code, chk_cp_ok, "code point out of range")
    `ASSERT_IMPLIES(a_noncode_zero, i_clk, i_rst_n, chk_nocode, chk_zero, "data on non-code")
    `ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, chk_end_in, chk_idle, "pending after end beat")

endmodule

`default_nettype wire
